@@ hdl/scsd_pkg.sv @@
// Shared types, constants and helper functions for the seed derivation pipeline.
package scsd_pkg;

	localparam int unsigned ROUNDS = 80;

	localparam logic [31:0] H0 = 32'h67452301;
	localparam logic [31:0] H1 = 32'hefcdab89;
	localparam logic [31:0] H2 = 32'h98badcfe;
	localparam logic [31:0] H3 = 32'h10325476;
	localparam logic [31:0] H4 = 32'hc3d2e1f0;

	localparam logic [31:0] K0 = 32'h5a827999;
	localparam logic [31:0] K1 = 32'h6ed9eba1;
	localparam logic [31:0] K2 = 32'h8f1bbcdc;
	localparam logic [31:0] K3 = 32'hca62c1d6;

	localparam logic [31:0] KEY_BASE = 32'hff2f0000;
	localparam logic [31:0] PM_FLAG = 32'h40000000;
	localparam logic [31:0] PAD_WORD = 32'h80000000;
	localparam logic [31:0] LEN_WORD = 32'h000001a0;
	localparam logic [31:0] BASE_OFS = 32'h00000054;
	localparam logic [16:0] NOON_SECS = 17'd43200;

	localparam logic [63:0] LCG_MUL = 64'h5d588b656c078965;
	localparam logic [63:0] LCG_ADD = 64'h0000000000269ec3;

	// Register indexes of the configuration port
	localparam logic [2:0] REG_LANG = 3'd0;
	localparam logic [2:0] REG_VER = 3'd1;
	localparam logic [2:0] REG_CONS = 3'd2;
	localparam logic [2:0] REG_VCNT = 3'd3;
	localparam logic [2:0] REG_MAC = 3'd4;
	localparam logic [2:0] REG_FRAME = 3'd5;
	localparam logic [2:0] REG_STAT = 3'd6;

	typedef logic [31:0] word_t;
	typedef word_t [15:0] block_t;

	// Working state of one compression lane
	typedef struct packed {
		word_t a;
		word_t b;
		word_t c;
		word_t d;
		word_t e;
	} sha_state_t;

	// One beat moving down the round pipeline: state plus message schedule window
	typedef struct packed {
		logic vld;
		sha_state_t st;
		block_t win;
	} rnd_beat_t;

	function automatic word_t bswap32(input word_t x);
		return {x[7:0], x[15:8], x[23:16], x[31:24]};
	endfunction

	function automatic word_t rotl1(input word_t x);
		return {x[30:0], x[31]};
	endfunction

	function automatic word_t rotl5(input word_t x);
		return {x[26:0], x[31:27]};
	endfunction

	function automatic word_t rotl30(input word_t x);
		return {x[1:0], x[31:2]};
	endfunction

	// Table word by language, version set and slot (0 plain, 1 alt, 2 w0, 3 w1)
	function automatic word_t tbl_word(input logic [2:0] lang, input logic set,
			input logic [1:0] slot);
		word_t r;
		r = '0;
		unique case ({lang, set, slot})
			6'b000_0_00: r = 32'h02200010; 6'b000_0_01: r = 32'h027a5f70;
			6'b000_0_10: r = 32'h0209aee8; 6'b000_0_11: r = 32'h02039de9;
			6'b000_1_00: r = 32'h02200050; 6'b000_1_01: r = 32'h027a5e90;
			6'b000_1_10: r = 32'h0209af28; 6'b000_1_11: r = 32'h02039e15;
			6'b001_0_00: r = 32'h021fffd0; 6'b001_0_01: r = 32'h027a6070;
			6'b001_0_10: r = 32'h0209aea8; 6'b001_0_11: r = 32'h02039db9;
			6'b001_1_00: r = 32'h021ffff0; 6'b001_1_01: r = 32'h027a5fb0;
			6'b001_1_10: r = 32'h0209aec8; 6'b001_1_11: r = 32'h02039de5;
			6'b010_0_00: r = 32'h02200030; 6'b010_0_01: r = 32'h027a5f90;
			6'b010_0_10: r = 32'h0209af08; 6'b010_0_11: r = 32'h02039df9;
			6'b010_1_00: r = 32'h02200050; 6'b010_1_01: r = 32'h027a5ef0;
			6'b010_1_10: r = 32'h0209af28; 6'b010_1_11: r = 32'h02039e25;
			6'b011_0_00: r = 32'h021fff10; 6'b011_0_01: r = 32'h027a5f70;
			6'b011_0_10: r = 32'h0209ade8; 6'b011_0_11: r = 32'h02039d69;
			6'b011_1_00: r = 32'h021fff50; 6'b011_1_01: r = 32'h027a5ed0;
			6'b011_1_10: r = 32'h0209ae28; 6'b011_1_11: r = 32'h02039d95;
			6'b100_0_00: r = 32'h021fff50; 6'b100_0_01: r = 32'h027a6110;
			6'b100_0_10: r = 32'h0209ae28; 6'b100_0_11: r = 32'h02039d69;
			6'b100_1_00: r = 32'h021fff70; 6'b100_1_01: r = 32'h027a6010;
			6'b100_1_10: r = 32'h0209ae48; 6'b100_1_11: r = 32'h02039d95;
			6'b101_0_00: r = 32'h021ff9b0; 6'b101_0_01: r = 32'h027aa730;
			6'b101_0_10: r = 32'h0209a8dc; 6'b101_0_11: r = 32'h02039ac9;
			6'b101_1_00: r = 32'h021ff9d0; 6'b101_1_01: r = 32'h027aa5f0;
			6'b101_1_10: r = 32'h0209a8fc; 6'b101_1_11: r = 32'h02039af5;
			6'b110_0_00: r = 32'h02200750; 6'b110_0_01: r = 32'h02200770;
			6'b110_0_10: r = 32'h0209b60c; 6'b110_0_11: r = 32'h0203a4d5;
			6'b110_1_00: r = 32'h02200770; 6'b110_1_01: r = 32'h027a57b0;
			6'b110_1_10: r = 32'h0209b62c; 6'b110_1_11: r = 32'h0203a501;
			default: r = '0;
		endcase
		return r;
	endfunction

	// Month offset (153 * mm + 2) / 5 for the shifted month 0..12
	function automatic logic [8:0] day_ofs(input logic [3:0] mm);
		logic [8:0] r;
		r = '0;
		unique case (mm)
			4'd0:  r = 9'd0;
			4'd1:  r = 9'd31;
			4'd2:  r = 9'd61;
			4'd3:  r = 9'd92;
			4'd4:  r = 9'd122;
			4'd5:  r = 9'd153;
			4'd6:  r = 9'd184;
			4'd7:  r = 9'd214;
			4'd8:  r = 9'd245;
			4'd9:  r = 9'd275;
			4'd10: r = 9'd306;
			4'd11: r = 9'd337;
			4'd12: r = 9'd367;
			default: r = '0;
		endcase
		return r;
	endfunction

	// Remainder by 7: octal digit sums, since 8 is 1 mod 7
	function automatic logic [2:0] mod7(input logic [21:0] x);
		logic [5:0] s1;
		logic [3:0] s2;
		logic [3:0] s3;
		s1 = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9]) + 6'(x[14:12])
			+ 6'(x[17:15]) + 6'(x[20:18]) + 6'(x[21]);
		s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
		s3 = 4'(s2[3]) + 4'(s2[2:0]);
		return (s3 >= 4'd7) ? 3'(s3 - 4'd7) : s3[2:0];
	endfunction

	// Two BCD digits of a value below 100 (tens by reciprocal of 10)
	function automatic logic [7:0] to_bcd(input logic [6:0] v);
		logic [14:0] p;
		logic [3:0]  tens;
		logic [6:0]  rem;
		p = 15'(v) * 15'd205;
		tens = p[14:11];
		rem = v - 7'(tens) * 7'd10;
		return {tens, rem[3:0]};
	endfunction

endpackage

@@ hdl/scsd_msg.sv @@
// Message block builder: date, time and key words, three register stages.
module scsd_msg
	import scsd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_vld,
	input  logic [11:0] year_value,
	input  logic [3:0]  month_value,
	input  logic [4:0]  day_value,
	input  logic [16:0] second_of_day,
	input  logic [11:0] button_mask,
	input  logic [15:0] timer_value,
	input  logic [2:0]  lang,
	input  logic [1:0]  ver,
	input  logic [1:0]  cons,
	input  logic [7:0]  vcnt,
	input  logic [47:0] mac,
	input  logic [6:0]  frame,
	input  logic [6:0]  stat,
	output logic        out_vld,
	output block_t      out_blk
);

	// Stage 1: shifted year and month, quotients by reciprocal, hour, key word
	logic        vld_s1, vld_s2, vld_s3;
	logic [13:0] yy_s1;
	logic [8:0]  ofs_s1;
	logic [6:0]  q100_s1;
	logic [4:0]  q400_s1;
	logic [6:0]  yr_s1;
	logic [3:0]  mon_s1;
	logic [4:0]  day_s1;
	logic [5:0]  hour_s1;
	logic [16:0] sec_s1;
	logic        noon_s1;
	word_t       kw_s1;
	logic [15:0] tmr_s1;

	logic [13:0] yy;
	logic [3:0]  mm;
	logic [23:0] p100, p400;
	logic [26:0] phr;
	logic [21:0] pyr;
	logic [6:0]  yr;
	word_t       kw;
	always_comb begin
		logic adj;
		adj = month_value < 4'd3;
		yy = 14'(year_value) + 14'd4800 - 14'(adj);
		mm = adj ? month_value + 4'd9 : month_value - 4'd3;
		// yy/100 = (yy/4)/25 and yy/400 = (yy/16)/25
		p100 = 24'(yy[13:2]) * 24'd2622;
		p400 = 24'(yy[13:4]) * 24'd2622;
		// hour = (secs/16)/225
		phr = 27'(second_of_day[16:4]) * 27'd9321;
		// year mod 100 via (year/4)/25
		pyr = 22'(year_value[11:2]) * 22'd2622;
		yr = 7'(year_value - 12'(pyr[21:16]) * 12'd100);
		// held keys map to bits 16..19 and 24..31
		kw = KEY_BASE - {button_mask[11:4], 4'h0, button_mask[3:0], 16'h0000};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		yy_s1   <= yy;
		ofs_s1  <= day_ofs(mm);
		q100_s1 <= p100[22:16];
		q400_s1 <= p400[20:16];
		yr_s1   <= yr;
		mon_s1  <= month_value;
		day_s1  <= day_value;
		hour_s1 <= phr[26:21];
		sec_s1  <= second_of_day;
		noon_s1 <= second_of_day >= NOON_SECS;
		kw_s1   <= kw;
		tmr_s1  <= timer_value;
	end

	// Stage 2: day number, remaining seconds, minute
	logic [21:0] jd_s2;
	logic [6:0]  yr_s2;
	logic [3:0]  mon_s2;
	logic [4:0]  day_s2;
	logic [5:0]  hour_s2;
	logic [11:0] rsec_s2;
	logic [5:0]  min_s2;
	logic        noon_s2;
	word_t       kw_s2;
	logic [15:0] tmr_s2;

	logic [11:0] rs;
	logic [19:0] pmn;
	logic [21:0] jd;
	always_comb begin
		rs = 12'(sec_s1 - 17'(hour_s1) * 17'd3600);
		// minute = (rs/4)/15
		pmn = 20'(rs[11:2]) * 20'd1093;
		// day number plus one, never wraps for 12-bit years
		jd = 22'(day_s1) + 22'(ofs_s1) + 22'd365 * 22'(yy_s1) + 22'(yy_s1[13:2])
			- 22'(q100_s1) + 22'(q400_s1) - 22'd32044;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		jd_s2   <= jd;
		yr_s2   <= yr_s1;
		mon_s2  <= mon_s1;
		day_s2  <= day_s1;
		hour_s2 <= hour_s1;
		rsec_s2 <= rs;
		min_s2  <= pmn[19:14];
		noon_s2 <= noon_s1;
		kw_s2   <= kw_s1;
		tmr_s2  <= tmr_s1;
	end

	// Stage 3: assemble the sixteen message words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	block_t blk;
	always_comb begin
		logic  set;
		logic [2:0] l;
		logic [5:0] sc;
		logic [2:0] wd;
		word_t base, w3, w9;
		l = (lang > 3'd6) ? 3'd6 : lang;
		set = ver != 2'd2;
		base = tbl_word(l, set, (cons != 2'd0) ? 2'd1 : 2'd0);
		w3 = bswap32(base + BASE_OFS);
		sc = 6'(rsec_s2 - 12'(min_s2) * 12'd60);
		wd = mod7(jd_s2);
		w9 = {to_bcd(7'(hour_s2)), to_bcd(7'(min_s2)), to_bcd(7'(sc)), 8'h00};
		if (hour_s2 >= 6'd12) w9 = w9 | PM_FLAG;
		if (noon_s2 && cons == 2'd2) w9 = w9 ^ PM_FLAG;
		blk = '0;
		blk[0] = bswap32(tbl_word(l, set, 2'd2));
		blk[1] = bswap32(tbl_word(l, set, 2'd3));
		blk[2] = bswap32(base);
		blk[3] = w3;
		blk[4] = w3;
		blk[5] = bswap32({8'h00, vcnt, tmr_s2});
		blk[6] = {16'h0000, mac[15:0]};
		blk[7] = mac[47:16] ^ {1'b0, frame, 24'h000000} ^ {25'h0, stat};
		blk[8] = {to_bcd(yr_s2), to_bcd({3'b000, mon_s2}), to_bcd({2'b00, day_s2}),
			5'b00000, wd};
		blk[9] = w9;
		blk[12] = kw_s2;
		blk[13] = PAD_WORD;
		blk[15] = LEN_WORD;
	end

	always_ff @(posedge clk) begin
		out_blk <= blk;
	end

	assign out_vld = vld_s3;

endmodule

@@ hdl/scsd_round.sv @@
// One registered SHA-1 round with in-place message schedule update.
module scsd_round
	import scsd_pkg::*;
#(
	parameter int unsigned IDX = 0
)
(
	input  logic      clk,
	input  logic      arst_n,
	input  rnd_beat_t din,
	output rnd_beat_t dout
);

	rnd_beat_t nxt;
	always_comb begin
		word_t f, k, wi, wn;
		sha_state_t s;
		s = din.st;
		if (IDX < 20) begin
			f = (s.b & s.c) | (~s.b & s.d);
			k = K0;
		end else if (IDX < 40) begin
			f = s.b ^ s.c ^ s.d;
			k = K1;
		end else if (IDX < 60) begin
			f = (s.b & s.c) | (s.b & s.d) | (s.c & s.d);
			k = K2;
		end else begin
			f = s.b ^ s.c ^ s.d;
			k = K3;
		end
		wi = din.win[0];
		// next schedule word w[i+16] from the sliding window
		wn = rotl1(din.win[13] ^ din.win[8] ^ din.win[2] ^ din.win[0]);
		nxt.vld = din.vld;
		nxt.st.a = rotl5(s.a) + f + s.e + k + wi;
		nxt.st.b = s.a;
		nxt.st.c = rotl30(s.b);
		nxt.st.d = s.c;
		nxt.st.e = s.d;
		nxt.win = {wn, din.win[15:1]};
	end

	logic       vld_q;
	sha_state_t st_q;
	block_t     win_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= nxt.vld;
		end
	end

	always_ff @(posedge clk) begin
		st_q  <= nxt.st;
		win_q <= nxt.win;
	end

	assign dout = {vld_q, st_q, win_q};

endmodule

@@ hdl/scsd_lcg.sv @@
// Digest finalization and the 64-bit LCG step, multiply split over stages.
module scsd_lcg
	import scsd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_vld,
	input  sha_state_t  st,
	output logic        out_vld,
	output logic [63:0] seed
);

	// Stage 1: add initial values and byte-swap into the 64-bit seed
	logic        vld_s1, vld_s2, vld_s3;
	logic [63:0] s_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		s_s1 <= {bswap32(st.b + H1), bswap32(st.a + H0)};
	end

	// Stage 2: 32x32 partial products (high x high is dropped mod 2^64)
	logic [63:0] ll_s2;
	logic [31:0] lh_s2, hl_s2;
	always_ff @(posedge clk) begin
		ll_s2 <= 64'(s_s1[31:0]) * 64'(LCG_MUL[31:0]);
		lh_s2 <= 32'(s_s1[31:0] * LCG_MUL[63:32]);
		hl_s2 <= 32'(s_s1[63:32] * LCG_MUL[31:0]);
	end

	// Stage 3: combine partial products and add the increment
	always_ff @(posedge clk) begin
		seed <= ll_s2 + {lh_s2 + hl_s2, 32'h0} + LCG_ADD;
	end

	assign out_vld = vld_s3;

endmodule

@@ hdl/sha1_console_seed_derivation.sv @@
// Top level of the seed derivation pipeline: config registers, message, rounds, LCG.
// Usage:
//   Configuration: write reg_we with reg_index (0..6) and reg_data; registers
//   take the value at the clock edge. Write them only while no beat is in flight.
//   Input: a candidate beat is taken on every edge with start high and busy low.
//   busy is tied low: the pipeline takes one candidate every cycle.
//   Output: seed_valid is high for exactly one cycle with seed_out; the receiver
//   cannot stall and the pipeline never holds a result back.
//   Pipeline: the message build stages, 80 round stages (one per SHA-1 round)
//   and the seed finalization and LCG multiply stages, all registered in order.
//   Throughput: one seed per cycle, set by the fully unrolled round pipeline.
//   Reset: arst_n clears all valid bits and restores register defaults
//   (game_version 2, everything else 0); beats in flight are dropped.
module sha1_console_seed_derivation
	import scsd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [11:0] year_value,
	input  logic [3:0]  month_value,
	input  logic [4:0]  day_value,
	input  logic [16:0] second_of_day,
	input  logic [11:0] button_mask,
	input  logic [15:0] timer_value,
	input  logic        reg_we,
	input  logic [2:0]  reg_index,
	input  logic [47:0] reg_data,
	output logic        seed_valid,
	output logic [63:0] seed_out
);

	// Configuration registers
	logic [2:0]  lang_q;
	logic [1:0]  ver_q;
	logic [1:0]  cons_q;
	logic [7:0]  vcnt_q;
	logic [47:0] mac_q;
	logic [6:0]  frame_q;
	logic [6:0]  stat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lang_q  <= '0;
			ver_q   <= 2'd2;
			cons_q  <= '0;
			vcnt_q  <= '0;
			mac_q   <= '0;
			frame_q <= '0;
			stat_q  <= '0;
		end else if (reg_we) begin
			unique case (reg_index)
				REG_LANG:  lang_q  <= reg_data[2:0];
				REG_VER:   ver_q   <= reg_data[1:0];
				REG_CONS:  cons_q  <= reg_data[1:0];
				REG_VCNT:  vcnt_q  <= reg_data[7:0];
				REG_MAC:   mac_q   <= reg_data;
				REG_FRAME: frame_q <= reg_data[6:0];
				REG_STAT:  stat_q  <= reg_data[6:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// Message block build
	logic   m_vld;
	block_t m_blk;
	scsd_msg u_msg (
		.clk, .arst_n,
		.in_vld(start && !busy),
		.year_value, .month_value, .day_value, .second_of_day, .button_mask, .timer_value,
		.lang(lang_q), .ver(ver_q), .cons(cons_q), .vcnt(vcnt_q), .mac(mac_q),
		.frame(frame_q), .stat(stat_q),
		.out_vld(m_vld), .out_blk(m_blk)
	);

	// Round pipeline, one stage per round
	rnd_beat_t chain [ROUNDS+1];
	assign chain[0].vld = m_vld;
	assign chain[0].st = '{a: H0, b: H1, c: H2, d: H3, e: H4};
	assign chain[0].win = m_blk;

	for (genvar r = 0; r < ROUNDS; r++) begin : g_rnd
		scsd_round #(.IDX(r)) u_rnd (
			.clk, .arst_n,
			.din(chain[r]),
			.dout(chain[r+1])
		);
	end

	// Finalization and LCG step
	scsd_lcg u_lcg (
		.clk, .arst_n,
		.in_vld(chain[ROUNDS].vld),
		.st(chain[ROUNDS].st),
		.out_vld(seed_valid),
		.seed(seed_out)
	);

endmodule

@@ dv/tb_sha1_console_seed_derivation.sv @@
// Testbench for the seed derivation pipeline: directed and random candidates checked against a predictor.
module tb_sha1_console_seed_derivation;
	import scsd_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PIPE_LAT = 86;
	localparam longint CYCLE_LIMIT = 400000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [11:0] year_value;
	logic [3:0]  month_value;
	logic [4:0]  day_value;
	logic [16:0] second_of_day;
	logic [11:0] button_mask;
	logic [15:0] timer_value;
	logic        reg_we;
	logic [2:0]  reg_index;
	logic [47:0] reg_data;
	logic        seed_valid;
	logic [63:0] seed_out;

	// predictor copy of the registers
	logic [2:0]  m_lang;
	logic [1:0]  m_ver;
	logic [1:0]  m_cons;
	logic [7:0]  m_vcnt;
	logic [47:0] m_mac;
	logic [6:0]  m_frame;
	logic [6:0]  m_stat;

	logic [63:0] seed_q[$];
	int          err_cnt;
	int          beat_cnt;
	int          seed_cnt;
	longint      cyc;

	sha1_console_seed_derivation DUT (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// timeout watchdog
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cyc);
			$display("FAILED: results differ");
			$finish;
		end
	end

	function automatic logic [31:0] swap32(input logic [31:0] x);
		return {x[7:0], x[15:8], x[23:16], x[31:24]};
	endfunction

	function automatic logic [31:0] rol(input logic [31:0] x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	function automatic logic [7:0] bcd2(input logic [31:0] v);
		logic [31:0] t;
		logic [31:0] o;
		t = v / 10;
		o = v % 10;
		return {t[3:0], o[3:0]};
	endfunction

	function automatic logic [31:0] lang_word(input int l, input int s, input int k);
		logic [31:0] tw[7][2][4];
		tw = '{
			'{'{32'h02200010, 32'h027a5f70, 32'h0209aee8, 32'h02039de9},
			  '{32'h02200050, 32'h027a5e90, 32'h0209af28, 32'h02039e15}},
			'{'{32'h021fffd0, 32'h027a6070, 32'h0209aea8, 32'h02039db9},
			  '{32'h021ffff0, 32'h027a5fb0, 32'h0209aec8, 32'h02039de5}},
			'{'{32'h02200030, 32'h027a5f90, 32'h0209af08, 32'h02039df9},
			  '{32'h02200050, 32'h027a5ef0, 32'h0209af28, 32'h02039e25}},
			'{'{32'h021fff10, 32'h027a5f70, 32'h0209ade8, 32'h02039d69},
			  '{32'h021fff50, 32'h027a5ed0, 32'h0209ae28, 32'h02039d95}},
			'{'{32'h021fff50, 32'h027a6110, 32'h0209ae28, 32'h02039d69},
			  '{32'h021fff70, 32'h027a6010, 32'h0209ae48, 32'h02039d95}},
			'{'{32'h021ff9b0, 32'h027aa730, 32'h0209a8dc, 32'h02039ac9},
			  '{32'h021ff9d0, 32'h027aa5f0, 32'h0209a8fc, 32'h02039af5}},
			'{'{32'h02200750, 32'h02200770, 32'h0209b60c, 32'h0203a4d5},
			  '{32'h02200770, 32'h027a57b0, 32'h0209b62c, 32'h0203a501}}};
		return tw[l][s][k];
	endfunction

	// seed for one candidate under the current register copy
	function automatic logic [63:0] calc_seed(input logic [11:0] yr, input logic [3:0] mo,
			input logic [4:0] dy, input logic [16:0] sec, input logic [11:0] keys,
			input logic [15:0] tmr);
		logic [31:0] w[80];
		logic [31:0] y, m, d, adj, yy, mm, jd, hr, mi, sc, base, kw;
		logic [31:0] a, b, c, dd, e, f, k, tmp;
		logic [63:0] s;
		int l, st;
		l = (m_lang > 6) ? 6 : int'(m_lang);
		st = (m_ver == 2'd2) ? 0 : 1;
		base = lang_word(l, st, (m_cons != 0) ? 1 : 0);
		for (int i = 0; i < 80; i++) w[i] = '0;
		w[0] = swap32(lang_word(l, st, 2));
		w[1] = swap32(lang_word(l, st, 3));
		w[2] = swap32(base);
		w[3] = swap32(base + 32'h54);
		w[4] = w[3];
		w[5] = swap32({8'h00, m_vcnt, tmr});
		w[6] = {16'h0, m_mac[15:0]};
		w[7] = m_mac[47:16] ^ ({25'h0, m_frame} << 24) ^ {25'h0, m_stat};
		y = 32'(yr); m = 32'(mo); d = 32'(dy);
		adj = (m < 3) ? 1 : 0;
		yy = y + 4800 - adj;
		mm = m + 12 * adj - 3;
		jd = d + ((153 * mm + 2) / 5) - 32045 + 365 * yy + yy / 4 - yy / 100 + yy / 400;
		w[8] = {bcd2(y % 100), bcd2(m), bcd2(d), 8'h00} | ((jd + 1) % 7);
		hr = sec / 3600;
		mi = (sec % 3600) / 60;
		sc = sec % 60;
		w[9] = {bcd2(hr), bcd2(mi), bcd2(sc), 8'h00};
		if (hr >= 12) w[9] = w[9] | 32'h40000000;
		if (sec >= 17'd43200 && m_cons == 2'd2) w[9] = w[9] ^ 32'h40000000;
		kw = 32'hff2f0000;
		for (int i = 0; i < 12; i++)
			if (keys[i]) kw = kw - ((i < 4) ? (32'h10000 << i) : (32'h1000000 << (i - 4)));
		w[12] = kw;
		w[13] = 32'h80000000;
		w[15] = 32'h000001a0;
		for (int i = 16; i < 80; i++) w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
		a = 32'h67452301; b = 32'hefcdab89; c = 32'h98badcfe; dd = 32'h10325476;
		e = 32'hc3d2e1f0;
		for (int i = 0; i < 80; i++) begin
			if (i < 20) begin
				f = (b & c) | (~b & dd); k = 32'h5a827999;
			end else if (i < 40) begin
				f = b ^ c ^ dd; k = 32'h6ed9eba1;
			end else if (i < 60) begin
				f = (b & c) | (b & dd) | (c & dd); k = 32'h8f1bbcdc;
			end else begin
				f = b ^ c ^ dd; k = 32'hca62c1d6;
			end
			tmp = rol(a, 5) + f + e + k + w[i];
			e = dd; dd = c; c = rol(b, 30); b = a; a = tmp;
		end
		s = {swap32(b + 32'hefcdab89), swap32(a + 32'h67452301)};
		return s * 64'h5d588b656c078965 + 64'h269ec3;
	endfunction

	task automatic report_err(input string msg);
		err_cnt++;
		$display("mismatch @%0d: %s", cyc, msg);
	endtask

	// result checker; the receiver cannot stall, so every valid seed is checked in order
	always @(posedge clk) begin
		if (arst_n && seed_valid) begin
			seed_cnt++;
			if (seed_q.size() == 0) report_err("seed with no candidate pending");
			else begin
				logic [63:0] exp_seed;
				exp_seed = seed_q.pop_front();
				if (seed_out !== exp_seed)
					report_err($sformatf("seed_out %h exp %h", seed_out, exp_seed));
			end
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [47:0] val);
		reg_we <= 1'b1;
		reg_index <= idx;
		reg_data <= val;
		@(posedge clk);
		case (idx)
			REG_LANG: m_lang = val[2:0];
			REG_VER: m_ver = val[1:0];
			REG_CONS: m_cons = val[1:0];
			REG_VCNT: m_vcnt = val[7:0];
			REG_MAC: m_mac = val;
			REG_FRAME: m_frame = val[6:0];
			REG_STAT: m_stat = val[6:0];
			default: ;
		endcase
	endtask

	// wait until the pipeline has drained
	task automatic drain();
		start <= 1'b0;
		while (seed_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_config(input logic [2:0] l, input logic [1:0] v, input logic [1:0] c,
			input logic [7:0] vc, input logic [47:0] mac, input logic [6:0] fr,
			input logic [6:0] sv);
		drain();
		write_reg(REG_LANG, {45'h0, l});
		write_reg(REG_VER, {46'h0, v});
		write_reg(REG_CONS, {46'h0, c});
		write_reg(REG_VCNT, {40'h0, vc});
		write_reg(REG_MAC, mac);
		write_reg(REG_FRAME, {41'h0, fr});
		write_reg(REG_STAT, {41'h0, sv});
		reg_we <= 1'b0;
	endtask

	int burst_left;

	// one candidate beat, with bursty gaps before it
	task automatic send_beat(input logic [11:0] yr, input logic [3:0] mo, input logic [4:0] dy,
			input logic [16:0] sec, input logic [11:0] keys, input logic [15:0] tmr);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 12)) : 0;
			burst_left = int'($urandom_range(1, 30));
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		start <= 1'b1;
		year_value <= yr; month_value <= mo; day_value <= dy;
		second_of_day <= sec; button_mask <= keys; timer_value <= tmr;
		@(posedge clk);
		while (busy) @(posedge clk);
		seed_q.push_back(calc_seed(yr, mo, dy, sec, keys, tmr));
		beat_cnt++;
	endtask

	task automatic idle_line();
		start <= 1'b0;
		@(posedge clk);
	endtask

	// field extremes and the date/time corner cases
	task automatic test_directed();
		set_config(3'd0, 2'd2, 2'd0, 8'd0, 48'h0, 7'd0, 7'd0);
		send_beat(12'd2000, 4'd1, 5'd1, 17'd0, 12'h000, 16'h0000);
		send_beat(12'd2099, 4'd12, 5'd31, 17'd86399, 12'hfff, 16'hffff);
		send_beat(12'd2024, 4'd2, 5'd29, 17'd43199, 12'h001, 16'h1234);
		send_beat(12'd2024, 4'd3, 5'd1, 17'd43200, 12'h800, 16'h8000);
		send_beat(12'hfff, 4'hf, 5'h1f, 17'h1ffff, 12'haaa, 16'h5555);
		send_beat(12'd0, 4'd0, 5'd0, 17'd90000, 12'h555, 16'haaaa);
		set_config(3'd7, 2'd3, 2'd2, 8'hff, 48'hffffffffffff, 7'd127, 7'd127);
		send_beat(12'd2011, 4'd6, 5'd15, 17'd43200, 12'h0f0, 16'h00ff);
		send_beat(12'd2011, 4'd6, 5'd15, 17'd43199, 12'h0f0, 16'h00ff);
		send_beat(12'd2050, 4'd2, 5'd28, 17'd86399, 12'hfff, 16'hffff);
		send_beat(12'd2050, 4'd2, 5'd28, 17'd120000, 12'h000, 16'h0000);
		set_config(3'd6, 2'd0, 2'd3, 8'h5a, 48'ha5a5a5a5a5a5, 7'd99, 7'd0);
		send_beat(12'd2013, 4'd11, 5'd30, 17'd50000, 12'h3c3, 16'hbeef);
		send_beat(12'd2013, 4'd11, 5'd30, 17'd3600, 12'hc3c, 16'hcafe);
		set_config(3'd5, 2'd1, 2'd1, 8'h00, 48'h123456789abc, 7'd0, 7'd99);
		send_beat(12'd2099, 4'd12, 5'd31, 17'd43200, 12'h7ff, 16'h0001);
		idle_line();
	endtask

	// random candidates under random register settings
	task automatic test_random();
		for (int ph = 0; ph < 12; ph++) begin
			set_config(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
				2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
				48'({$urandom, $urandom}), 7'($urandom_range(0, 127)),
				7'($urandom_range(0, 127)));
			for (int n = 0; n < 70; n++) begin
				if ($urandom_range(0, 9) == 0)
					send_beat(12'($urandom), 4'($urandom), 5'($urandom), 17'($urandom),
						12'($urandom), 16'($urandom));
				else
					send_beat(12'($urandom_range(2000, 2099)), 4'($urandom_range(1, 12)),
						5'($urandom_range(1, 28)), 17'($urandom_range(0, 86399)),
						12'($urandom), 16'($urandom));
			end
			// hold off until the pipeline is empty, once after the sixth phase
			if (ph == 5) begin
				idle_line();
				drain();
			end
		end
		idle_line();
	endtask

	initial begin
		cyc = 0; err_cnt = 0; beat_cnt = 0; seed_cnt = 0; burst_left = 0;
		arst_n = 1'b0;
		start = 1'b0;
		year_value = '0; month_value = '0; day_value = '0; second_of_day = '0;
		button_mask = '0; timer_value = '0;
		reg_we = 1'b0; reg_index = '0; reg_data = '0;
		m_lang = 3'd0; m_ver = 2'd2; m_cons = 2'd0; m_vcnt = '0; m_mac = '0;
		m_frame = '0; m_stat = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// reset values first
		send_beat(12'd2010, 4'd9, 5'd18, 17'd45000, 12'h000, 16'h0c80);
		idle_line();
		test_directed();
		test_random();
		while (seed_q.size() != 0) @(posedge clk);
		repeat (PIPE_LAT + 10) @(posedge clk);
		$display("covered %0d candidates and %0d seeds", beat_cnt, seed_cnt);
		$display("under the reset defaults and 16 written register settings");
		if (err_cnt == 0) $display("PASSED: all results match");
		else $display("FAILED: results differ");
		$finish;
	end
endmodule
